FILE: hw/rtl/qebd_pkg.sv
// ----------------------------------------------------------------------------
// qebd_pkg
// Shared types, constants and the quadrature step function for the
// encoder and button decoder.
// ----------------------------------------------------------------------------
package qebd_pkg;

   // Number of encoder slots that the ports provide for.
   localparam int MAX_ENCODERS = 4;

   // Field widths of one transaction.
   localparam int PIN_WORD_WIDTH  = 16;
   localparam int TIME_WIDTH      = 32;
   localparam int POSITION_WIDTH  = 32;
   localparam int DEBOUNCE_WIDTH  = 16;
   localparam int PIN_MAP_WIDTH   = 48;
   localparam int PIN_SEL_WIDTH   = 4;
   localparam int ENC_FIELD_WIDTH = 3 * PIN_SEL_WIDTH;

   // Slots of the A, B and switch pin selects inside one encoder field.
   localparam int SLOT_A      = 0;
   localparam int SLOT_B      = 1;
   localparam int SLOT_SWITCH = 2;

   // Configuration port layout: registers sit on 8-byte boundaries.
   localparam int CSR_ADDR_WIDTH = 4;
   localparam int CSR_DATA_WIDTH = 64;
   localparam logic REG_DEBOUNCE = 1'b0;
   localparam logic REG_PIN_MAP  = 1'b1;

   // Register reset values.
   localparam logic [DEBOUNCE_WIDTH-1:0] DEBOUNCE_RESET = 16'd20;
   localparam logic [PIN_MAP_WIDTH-1:0]  PIN_MAP_RESET  = 48'h567DCBA98234;

   // Depth of the queue between the front and back sections.
   localparam int QUEUE_DEPTH = 2;

   // Step decoded from one A/B transition.
   typedef logic [1:0] step_type;
   localparam step_type STEP_NONE = 2'b00;
   localparam step_type STEP_UP   = 2'b01;
   localparam step_type STEP_DOWN = 2'b10;

   // One classified sample travelling from front to back.
   typedef struct packed {
      step_type [MAX_ENCODERS-1:0]  step;
      logic [MAX_ENCODERS-1:0]      fall;
      logic [TIME_WIDTH-1:0]        time_ms;
      logic [MAX_ENCODERS-1:0]      zero_mask;
      logic [MAX_ENCODERS-1:0]      ack_mask;
   } entry_type;

   // Gray-code quadrature table: previous {B,A} against current {B,A}.
   // Unchanged pins and double steps give no count.
   function automatic step_type quad_step(input logic [1:0] last_ab,
                                          input logic [1:0] cur_ab);
      step_type result;
      case ({last_ab, cur_ab})
         4'b0001, 4'b0111, 4'b1000, 4'b1110: result = STEP_UP;
         4'b0010, 4'b0100, 4'b1011, 4'b1101: result = STEP_DOWN;
         default:                            result = STEP_NONE;
      endcase
      return result;
   endfunction

endpackage

FILE: hw/rtl/qebd_front.sv
// ----------------------------------------------------------------------------
// qebd_front
// Accepts pin samples, picks the A, B and switch pins of every encoder and
// classifies each encoder into a step direction and a switch falling edge.
// ----------------------------------------------------------------------------
module qebd_front #(
   parameter int ENCODER_COUNT = 4
) (
   input  logic                                      clock,
   input  logic                                      reset,
   input  logic                                      req_valid,
   output logic                                      req_ready,
   input  logic [qebd_pkg::PIN_WORD_WIDTH-1:0]       req_pin_word,
   input  logic [qebd_pkg::TIME_WIDTH-1:0]           req_time_ms,
   input  logic [qebd_pkg::MAX_ENCODERS-1:0]         req_zero_mask,
   input  logic [qebd_pkg::MAX_ENCODERS-1:0]         req_ack_mask,
   input  logic [qebd_pkg::PIN_MAP_WIDTH-1:0]        pin_map,
   input  logic                                      queue_full,
   output logic                                      push,
   output qebd_pkg::entry_type                       entry
);
   import qebd_pkg::*;

   logic [MAX_ENCODERS-1:0][1:0] last_ab_ff;
   logic [MAX_ENCODERS-1:0][1:0] last_ab_in;
   logic [MAX_ENCODERS-1:0]      last_sw_ff;
   logic [MAX_ENCODERS-1:0]      last_sw_in;
   logic [MAX_ENCODERS-1:0][1:0] cur_ab;
   logic [MAX_ENCODERS-1:0]      cur_sw;

   // A transaction is taken whenever the queue has room.
   assign req_ready = !queue_full;
   assign push      = req_valid && req_ready;

   // Pin selection and classification for every encoder slot.
   always_comb begin
      entry.time_ms   = req_time_ms;
      entry.zero_mask = req_zero_mask;
      entry.ack_mask  = req_ack_mask;
      for (int i = 0; i < MAX_ENCODERS; i++) begin
         cur_ab[i][0] = req_pin_word[pin_map[i*ENC_FIELD_WIDTH + SLOT_A*PIN_SEL_WIDTH
                                             +: PIN_SEL_WIDTH]];
         cur_ab[i][1] = req_pin_word[pin_map[i*ENC_FIELD_WIDTH + SLOT_B*PIN_SEL_WIDTH
                                             +: PIN_SEL_WIDTH]];
         cur_sw[i]    = req_pin_word[pin_map[i*ENC_FIELD_WIDTH + SLOT_SWITCH*PIN_SEL_WIDTH
                                             +: PIN_SEL_WIDTH]];
         if (i < ENCODER_COUNT) begin
            entry.step[i] = quad_step(last_ab_ff[i], cur_ab[i]);
            entry.fall[i] = last_sw_ff[i] && !cur_sw[i];
            last_ab_in[i] = push ? cur_ab[i] : last_ab_ff[i];
            last_sw_in[i] = push ? cur_sw[i] : last_sw_ff[i];
         end else begin
            entry.step[i] = STEP_NONE;
            entry.fall[i] = 1'b0;
            last_ab_in[i] = last_ab_ff[i];
            last_sw_in[i] = last_sw_ff[i];
         end
      end
   end

   // Previous pin levels; idle pins are pulled high after reset.
   always_ff @(posedge clock) begin
      if (reset) begin
         last_ab_ff <= {MAX_ENCODERS{2'b11}};
         last_sw_ff <= {MAX_ENCODERS{1'b1}};
      end else begin
         last_ab_ff <= last_ab_in;
         last_sw_ff <= last_sw_in;
      end
   end

endmodule

FILE: hw/rtl/qebd_fifo.sv
// ----------------------------------------------------------------------------
// qebd_fifo
// Short queue of classified samples between the front and back sections.
// ----------------------------------------------------------------------------
module qebd_fifo (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 push,
   input  qebd_pkg::entry_type  push_entry,
   output logic                 full,
   input  logic                 pop,
   output logic                 pop_valid,
   output qebd_pkg::entry_type  pop_entry
);
   import qebd_pkg::*;

   localparam int PTR_WIDTH = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CNT_WIDTH = $clog2(QUEUE_DEPTH + 1);
   localparam logic [PTR_WIDTH-1:0] LAST_PTR = PTR_WIDTH'(QUEUE_DEPTH - 1);
   localparam logic [CNT_WIDTH-1:0] FULL_COUNT = CNT_WIDTH'(QUEUE_DEPTH);

   entry_type                entries_ff [QUEUE_DEPTH];
   logic [PTR_WIDTH-1:0]     wr_ptr_ff;
   logic [PTR_WIDTH-1:0]     wr_ptr_in;
   logic [PTR_WIDTH-1:0]     rd_ptr_ff;
   logic [PTR_WIDTH-1:0]     rd_ptr_in;
   logic [CNT_WIDTH-1:0]     count_ff;
   logic [CNT_WIDTH-1:0]     count_in;

   assign full      = (count_ff == FULL_COUNT);
   assign pop_valid = (count_ff != '0);
   assign pop_entry = entries_ff[rd_ptr_ff];

   // Pointer and occupancy update.
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == LAST_PTR) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == LAST_PTR) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Entry storage needs no reset.
   always_ff @(posedge clock) begin
      if (push) begin
         entries_ff[wr_ptr_ff] <= push_entry;
      end
   end

`ifndef SYNTHESIS
   a_no_push_when_full: assert property (@(posedge clock) disable iff (reset)
      push |-> (count_ff != FULL_COUNT))
      else $error("queue written while full");

   a_no_pop_when_empty: assert property (@(posedge clock) disable iff (reset)
      pop |-> (count_ff != '0))
      else $error("queue read while empty");
`endif

endmodule

FILE: hw/rtl/qebd_back.sv
// ----------------------------------------------------------------------------
// qebd_back
// Applies classified samples: clears and counts positions, debounces
// switch presses and holds the sticky press flags shown on the result port.
// ----------------------------------------------------------------------------
module qebd_back #(
   parameter int ENCODER_COUNT = 4
) (
   input  logic                                                    clock,
   input  logic                                                    reset,
   input  logic                                                    entry_valid,
   input  qebd_pkg::entry_type                                     entry,
   output logic                                                    entry_pop,
   input  logic [qebd_pkg::DEBOUNCE_WIDTH-1:0]                     debounce_ms,
   output logic                                                    rsp_valid,
   input  logic                                                    rsp_ready,
   output logic [qebd_pkg::MAX_ENCODERS-1:0][qebd_pkg::POSITION_WIDTH-1:0] position,
   output logic [qebd_pkg::MAX_ENCODERS-1:0]                       pressed_mask
);
   import qebd_pkg::*;

   logic                                          rsp_valid_ff;
   logic                                          rsp_valid_in;
   logic [MAX_ENCODERS-1:0][POSITION_WIDTH-1:0]   position_ff;
   logic [MAX_ENCODERS-1:0][POSITION_WIDTH-1:0]   position_in;
   logic [MAX_ENCODERS-1:0][POSITION_WIDTH-1:0]   position_base;
   logic [MAX_ENCODERS-1:0][TIME_WIDTH-1:0]       press_time_ff;
   logic [MAX_ENCODERS-1:0][TIME_WIDTH-1:0]       press_time_in;
   logic [MAX_ENCODERS-1:0][TIME_WIDTH-1:0]       elapsed;
   logic [MAX_ENCODERS-1:0]                       press_ff;
   logic [MAX_ENCODERS-1:0]                       press_in;

   // The state itself is the result; a new sample is applied only once
   // the previous result has been taken.
   assign entry_pop    = entry_valid && (!rsp_valid_ff || rsp_ready);
   assign rsp_valid_in = entry_pop || (rsp_valid_ff && !rsp_ready);
   assign rsp_valid    = rsp_valid_ff;
   assign position     = position_ff;
   assign pressed_mask = press_ff;

   // Per-encoder update: masks act first, then the step and the press.
   always_comb begin
      for (int i = 0; i < MAX_ENCODERS; i++) begin
         position_base[i] = entry.zero_mask[i] ? '0 : position_ff[i];
         elapsed[i]       = entry.time_ms - press_time_ff[i];
         position_in[i]   = position_ff[i];
         press_time_in[i] = press_time_ff[i];
         press_in[i]      = press_ff[i];
         if (entry_pop && (i < ENCODER_COUNT)) begin
            case (entry.step[i])
               STEP_UP:   position_in[i] = position_base[i] + 1'b1;
               STEP_DOWN: position_in[i] = position_base[i] - 1'b1;
               default:   position_in[i] = position_base[i];
            endcase
            press_in[i] = press_ff[i] && !entry.ack_mask[i];
            if (entry.fall[i] && (elapsed[i] > {{(TIME_WIDTH-DEBOUNCE_WIDTH){1'b0}},
                                                debounce_ms})) begin
               press_in[i]      = 1'b1;
               press_time_in[i] = entry.time_ms;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff  <= 1'b0;
         position_ff   <= '0;
         press_time_ff <= '0;
         press_ff      <= '0;
      end else begin
         rsp_valid_ff  <= rsp_valid_in;
         position_ff   <= position_in;
         press_time_ff <= press_time_in;
         press_ff      <= press_in;
      end
   end

`ifndef SYNTHESIS
   a_position_holds: assert property (@(posedge clock) disable iff (reset)
      !entry_pop |=> $stable(position_ff))
      else $error("position changed without a sample");

   a_press_holds: assert property (@(posedge clock) disable iff (reset)
      !entry_pop |=> $stable(press_ff))
      else $error("press flags changed without a sample");

   a_pop_gives_result: assert property (@(posedge clock) disable iff (reset)
      entry_pop |=> rsp_valid_ff)
      else $error("applied sample produced no result");
`endif

endmodule

FILE: hw/rtl/quad_encoder_button_decoder.sv
// An accepted transaction is written into the queue; the state update then applies
// it to the registered positions and press flags, which form the result.
// Throughput: one transaction per cycle while the queue has room; the two-entry
// queue between the classifier and the state update absorbs result-side stalls.
// Reset (synchronous, active high): registers return to their defaults, pins
// are taken as pulled high, positions and press state clear, the queue empties.
// ----------------------------------------------------------------------------
// quad_encoder_button_decoder
// Decodes up to four rotary encoders with push switches from captured pin
// words into wrapping positions and debounced sticky press flags.
// ----------------------------------------------------------------------------
module quad_encoder_button_decoder #(
   parameter int ENCODER_COUNT = 4
) (
   input  logic                                   clock,
   input  logic                                   reset,
   // Sample transactions
   input  logic                                   req_valid,
   output logic                                   req_ready,
   input  logic [qebd_pkg::PIN_WORD_WIDTH-1:0]    req_pin_word,
   input  logic [qebd_pkg::TIME_WIDTH-1:0]        req_time_ms,
   input  logic [qebd_pkg::MAX_ENCODERS-1:0]      req_zero_mask,
   input  logic [qebd_pkg::MAX_ENCODERS-1:0]      req_ack_mask,
   // Result transactions
   output logic                                   rsp_valid,
   input  logic                                   rsp_ready,
   output logic signed [qebd_pkg::POSITION_WIDTH-1:0] rsp_position_0,
   output logic signed [qebd_pkg::POSITION_WIDTH-1:0] rsp_position_1,
   output logic signed [qebd_pkg::POSITION_WIDTH-1:0] rsp_position_2,
   output logic signed [qebd_pkg::POSITION_WIDTH-1:0] rsp_position_3,
   output logic [qebd_pkg::MAX_ENCODERS-1:0]      rsp_pressed_mask,
   // Configuration port
   input  logic                                   psel,
   input  logic                                   penable,
   input  logic                                   pwrite,
   input  logic [qebd_pkg::CSR_ADDR_WIDTH-1:0]    paddr,
   input  logic [qebd_pkg::CSR_DATA_WIDTH-1:0]    pwdata,
   output logic [qebd_pkg::CSR_DATA_WIDTH-1:0]    prdata,
   output logic                                   pready
);
   import qebd_pkg::*;

   logic [DEBOUNCE_WIDTH-1:0]                     debounce_ff;
   logic [DEBOUNCE_WIDTH-1:0]                     debounce_in;
   logic [PIN_MAP_WIDTH-1:0]                      pin_map_ff;
   logic [PIN_MAP_WIDTH-1:0]                      pin_map_in;
   logic                                          csr_write;
   logic                                          reg_index;
   logic                                          push;
   logic                                          queue_full;
   entry_type                                     push_entry;
   logic                                          pop;
   logic                                          pop_valid;
   entry_type                                     pop_entry;
   logic [MAX_ENCODERS-1:0][POSITION_WIDTH-1:0]   position;

   // Register file: the upper address bit selects the register.
   assign pready    = 1'b1;
   assign csr_write = psel && penable && pwrite && pready;
   assign reg_index = paddr[CSR_ADDR_WIDTH-1];

   always_comb begin
      debounce_in = debounce_ff;
      pin_map_in  = pin_map_ff;
      if (csr_write) begin
         case (reg_index)
            REG_DEBOUNCE: debounce_in = pwdata[DEBOUNCE_WIDTH-1:0];
            REG_PIN_MAP:  pin_map_in  = pwdata[PIN_MAP_WIDTH-1:0];
            default:      debounce_in = debounce_ff;
         endcase
      end
   end

   always_comb begin
      case (reg_index)
         REG_DEBOUNCE: prdata = {{(CSR_DATA_WIDTH-DEBOUNCE_WIDTH){1'b0}}, debounce_ff};
         REG_PIN_MAP:  prdata = {{(CSR_DATA_WIDTH-PIN_MAP_WIDTH){1'b0}}, pin_map_ff};
         default:      prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         debounce_ff <= DEBOUNCE_RESET;
         pin_map_ff  <= PIN_MAP_RESET;
      end else begin
         debounce_ff <= debounce_in;
         pin_map_ff  <= pin_map_in;
      end
   end

   // Classifier section.
   qebd_front #(
      .ENCODER_COUNT (ENCODER_COUNT)
   ) u_front (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_pin_word  (req_pin_word),
      .req_time_ms   (req_time_ms),
      .req_zero_mask (req_zero_mask),
      .req_ack_mask  (req_ack_mask),
      .pin_map       (pin_map_ff),
      .queue_full    (queue_full),
      .push          (push),
      .entry         (push_entry)
   );

   // Queue between the sections.
   qebd_fifo u_fifo (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_entry (push_entry),
      .full       (queue_full),
      .pop        (pop),
      .pop_valid  (pop_valid),
      .pop_entry  (pop_entry)
   );

   // State update and result section.
   qebd_back #(
      .ENCODER_COUNT (ENCODER_COUNT)
   ) u_back (
      .clock        (clock),
      .reset        (reset),
      .entry_valid  (pop_valid),
      .entry        (pop_entry),
      .entry_pop    (pop),
      .debounce_ms  (debounce_ff),
      .rsp_valid    (rsp_valid),
      .rsp_ready    (rsp_ready),
      .position     (position),
      .pressed_mask (rsp_pressed_mask)
   );

   assign rsp_position_0 = $signed(position[0]);
   assign rsp_position_1 = $signed(position[1]);
   assign rsp_position_2 = $signed(position[2]);
   assign rsp_position_3 = $signed(position[3]);

endmodule
